// ----- hw/rtl/mm3_pkg.sv -----
`default_nettype none
package mm3_pkg;

  localparam int LANE_W  = 64;
  localparam int COUNT_W = 5;

  // What a mix core is asked to do with its 64-bit value.
  typedef enum logic [1:0] {
    MODE_LANE_ONE = 2'd0,
    MODE_LANE_TWO = 2'd1,
    MODE_FINAL    = 2'd2
  } mix_mode_t;

  typedef struct packed {
    logic              start;
    mix_mode_t         mode;
    logic [LANE_W-1:0] value;
  } mix_req_t;

  typedef struct packed {
    logic              done;
    logic [LANE_W-1:0] result;
  } mix_rsp_t;

endpackage
`default_nettype wire

// ----- hw/rtl/mm3_ifs.sv -----
`default_nettype none
interface mm3_block_if;
  logic                             valid;
  logic                             ready;
  logic [mm3_pkg::LANE_W-1:0]       lane_low;
  logic [mm3_pkg::LANE_W-1:0]       lane_high;
  logic [mm3_pkg::COUNT_W-1:0]      byte_count;
  logic                             last;

  modport source (output valid, lane_low, lane_high, byte_count, last, input ready);
  modport sink   (input valid, lane_low, lane_high, byte_count, last, output ready);
endinterface

interface mm3_digest_if;
  logic                       valid;
  logic                       ready;
  logic [mm3_pkg::LANE_W-1:0] digest_low;
  logic [mm3_pkg::LANE_W-1:0] digest_high;

  modport source (output valid, digest_low, digest_high, input ready);
  modport sink   (input valid, digest_low, digest_high, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/mm3_mix_core.sv -----
`default_nettype none
module mm3_mix_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mm3_pkg::mix_req_t req,
  output mm3_pkg::mix_rsp_t      rsp
);

  localparam logic [63:0] C1 = 64'h87c37b91114253d5;
  localparam logic [63:0] C2 = 64'h4cf5ad432745937f;
  localparam logic [63:0] F1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] F2 = 64'hc4ceb9fe1a85ec53;

  typedef enum logic [3:0] {
    CS_IDLE  = 4'b0001,
    CS_MUL_A = 4'b0010,
    CS_MUL_B = 4'b0100,
    CS_DONE  = 4'b1000
  } core_state_t;

  core_state_t        state;
  logic [1:0]         phase;
  mm3_pkg::mix_mode_t mode;
  logic [63:0]        v;
  logic [63:0]        pp_lo;
  logic [31:0]        cross_a;
  logic [31:0]        cross_b;

  logic [63:0] mult_k;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] prod;
  logic [63:0] full_prod;

  function automatic logic [63:0] xshift33(input logic [63:0] x);
    return x ^ {33'b0, x[63:33]};
  endfunction

  function automatic logic [63:0] const_a(input mm3_pkg::mix_mode_t m);
    logic [63:0] k;
    unique case (m)
      mm3_pkg::MODE_LANE_ONE: k = C1;
      mm3_pkg::MODE_LANE_TWO: k = C2;
      mm3_pkg::MODE_FINAL:    k = F1;
      default:                k = C1;
    endcase
    return k;
  endfunction

  function automatic logic [63:0] const_b(input mm3_pkg::mix_mode_t m);
    logic [63:0] k;
    unique case (m)
      mm3_pkg::MODE_LANE_ONE: k = C2;
      mm3_pkg::MODE_LANE_TWO: k = C1;
      mm3_pkg::MODE_FINAL:    k = F2;
      default:                k = C2;
    endcase
    return k;
  endfunction

  function automatic logic [63:0] pre_op(input mm3_pkg::mix_mode_t m, input logic [63:0] x);
    return (m == mm3_pkg::MODE_FINAL) ? xshift33(x) : x;
  endfunction

  function automatic logic [63:0] mid_op(input mm3_pkg::mix_mode_t m, input logic [63:0] x);
    logic [63:0] y;
    unique case (m)
      mm3_pkg::MODE_LANE_ONE: y = {x[32:0], x[63:33]};  // rotl 31
      mm3_pkg::MODE_LANE_TWO: y = {x[30:0], x[63:31]};  // rotl 33
      mm3_pkg::MODE_FINAL:    y = xshift33(x);
      default:                y = x;
    endcase
    return y;
  endfunction

  // 64x64 low product from three 32x32 partials, one per cycle, then combined in a final step.
  assign mult_k    = (state == CS_MUL_A) ? const_a(mode) : const_b(mode);
  assign op_a      = (phase == 2'd1) ? v[63:32] : v[31:0];
  assign op_b      = (phase == 2'd2) ? mult_k[63:32] : mult_k[31:0];
  assign prod      = op_a * op_b;
  assign full_prod = pp_lo + {cross_a + cross_b, 32'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
      phase <= 2'd0;
      mode  <= mm3_pkg::MODE_LANE_ONE;
    end else begin
      unique case (state)
        CS_IDLE: begin
          if (req.start) begin
            v     <= pre_op(req.mode, req.value);
            mode  <= req.mode;
            phase <= 2'd0;
            state <= CS_MUL_A;
          end
        end
        CS_MUL_A, CS_MUL_B: begin
          phase <= phase + 2'd1;
          unique case (phase)
            2'd0: pp_lo   <= prod;
            2'd1: cross_a <= prod[31:0];
            2'd2: cross_b <= prod[31:0];
            2'd3: begin
              if (state == CS_MUL_A) begin
                v     <= mid_op(mode, full_prod);
                state <= CS_MUL_B;
              end else begin
                v     <= (mode == mm3_pkg::MODE_FINAL) ? xshift33(full_prod) : full_prod;
                state <= CS_DONE;
              end
            end
            default: ;
          endcase
        end
        CS_DONE: state <= CS_IDLE;
        default: state <= CS_IDLE;
      endcase
    end
  end

  assign rsp.done   = (state == CS_DONE);
  assign rsp.result = v;

endmodule
`default_nettype wire

// ----- hw/rtl/murmur3_x64_128_hash_unit.sv -----
// A body word keeps the unit busy through mix and merge; no new word is taken meanwhile.
// A last word raises digest valid after finalization (a partial tail skips the merge);
// the next word can be taken as digest valid rises, or later if an older digest waits.
// The busy spans are set by the mix cores: two 64-bit constant multiplies each, built
// from three 32x32 partial products on one shared multiplier plus a combine step.
// Reset (synchronous, rst high) clears the accumulators, byte count and output valid.
`default_nettype none
module murmur3_x64_128_hash_unit (
  input  wire logic   clk,
  input  wire logic   rst,
  mm3_block_if.sink   blk,
  mm3_digest_if.source digest
);

  localparam logic [63:0] ADD1 = 64'h0000000052dce729;
  localparam logic [63:0] ADD2 = 64'h0000000038495ab5;

  typedef enum logic [10:0] {
    ST_IDLE       = 11'b00000000001,
    ST_MIX        = 11'b00000000010,
    ST_MERGE_ONE  = 11'b00000000100,
    ST_MERGE_TWO  = 11'b00000001000,
    ST_FIN_XOR    = 11'b00000010000,
    ST_FIN_ADD    = 11'b00000100000,
    ST_FIN_LAUNCH = 11'b00001000000,
    ST_FIN_MIX    = 11'b00010000000,
    ST_FIN_SUM_1  = 11'b00100000000,
    ST_FIN_SUM_2  = 11'b01000000000,
    ST_EMIT       = 11'b10000000000
  } state_t;

  state_t      state;
  state_t      state_next;
  logic        last_q;
  logic        tail_q;
  logic [63:0] acc_one;
  logic [63:0] acc_two;
  logic [63:0] total_bytes;
  logic        out_valid;
  logic [63:0] dig_low;
  logic [63:0] dig_high;

  mm3_pkg::mix_req_t req_one;
  mm3_pkg::mix_req_t req_two;
  mm3_pkg::mix_rsp_t rsp_one;
  mm3_pkg::mix_rsp_t rsp_two;

  logic        accept;
  logic        launch;
  logic        out_free;
  logic        is_tail;
  logic [4:0]  add_bytes;
  logic [3:0]  lo_n;
  logic [3:0]  hi_n;
  logic [63:0] lo_masked;
  logic [63:0] hi_masked;
  logic [63:0] x_one;
  logic [63:0] x_two;
  logic [63:0] t_one;
  logic [63:0] t_two;
  logic [63:0] merge_one;
  logic [63:0] merge_two;

  // keep the low n bytes, n in 0..8
  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    for (int i = 0; i < 8; i++) begin
      m[8*i +: 8] = (4'(i) < n) ? 8'hff : 8'h00;
    end
    return m;
  endfunction

  assign accept   = blk.valid && blk.ready;
  assign launch   = (state == ST_FIN_LAUNCH);
  assign out_free = !out_valid || digest.ready;

  // a last word with fewer than 16 bytes is a tail; anything above 16 counts as 16
  assign is_tail   = blk.last && (blk.byte_count < 5'd16);
  assign add_bytes = is_tail ? blk.byte_count : 5'd16;
  assign lo_n      = blk.byte_count[3] ? 4'd8 : {1'b0, blk.byte_count[2:0]};
  assign hi_n      = blk.byte_count[3] ? {1'b0, blk.byte_count[2:0]} : 4'd0;
  assign lo_masked = is_tail ? (blk.lane_low & byte_mask(lo_n)) : blk.lane_low;
  assign hi_masked = is_tail ? (blk.lane_high & byte_mask(hi_n)) : blk.lane_high;

  // masked-out lanes mix to zero, so both cores always run
  assign req_one.start = accept || launch;
  assign req_one.mode  = launch ? mm3_pkg::MODE_FINAL : mm3_pkg::MODE_LANE_ONE;
  assign req_one.value = launch ? acc_one : lo_masked;
  assign req_two.start = accept || launch;
  assign req_two.mode  = launch ? mm3_pkg::MODE_FINAL : mm3_pkg::MODE_LANE_TWO;
  assign req_two.value = launch ? acc_two : hi_masked;

  mm3_mix_core u_core_one (
    .clk (clk),
    .rst (rst),
    .req (req_one),
    .rsp (rsp_one)
  );

  mm3_mix_core u_core_two (
    .clk (clk),
    .rst (rst),
    .req (req_two),
    .rsp (rsp_two)
  );

  // body merge: x*5 + c as shift-add
  assign x_one     = acc_one ^ rsp_one.result;
  assign t_one     = {x_one[36:0], x_one[63:37]} + acc_two;
  assign merge_one = {t_one[61:0], 2'b00} + t_one + ADD1;
  assign x_two     = acc_two ^ rsp_two.result;
  assign t_two     = {x_two[32:0], x_two[63:33]} + acc_one;
  assign merge_two = {t_two[61:0], 2'b00} + t_two + ADD2;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:       if (accept) state_next = ST_MIX;
      ST_MIX: begin
        if (rsp_one.done) state_next = tail_q ? ST_FIN_XOR : ST_MERGE_ONE;
      end
      ST_MERGE_ONE:  state_next = ST_MERGE_TWO;
      ST_MERGE_TWO:  state_next = last_q ? ST_FIN_XOR : ST_IDLE;
      ST_FIN_XOR:    state_next = ST_FIN_ADD;
      ST_FIN_ADD:    state_next = ST_FIN_LAUNCH;
      ST_FIN_LAUNCH: state_next = ST_FIN_MIX;
      ST_FIN_MIX:    if (rsp_one.done) state_next = ST_FIN_SUM_1;
      ST_FIN_SUM_1:  state_next = ST_FIN_SUM_2;
      ST_FIN_SUM_2:  state_next = ST_EMIT;
      ST_EMIT:       if (out_free) state_next = ST_IDLE;
      default:       state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      last_q      <= 1'b0;
      tail_q      <= 1'b0;
      acc_one     <= '0;
      acc_two     <= '0;
      total_bytes <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_EMIT && out_free) out_valid <= 1'b1;
      else if (digest.ready)            out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            total_bytes <= total_bytes + {59'b0, add_bytes};
            last_q      <= blk.last;
            tail_q      <= is_tail;
          end
        end
        ST_MIX: begin
          if (rsp_one.done && tail_q) begin
            acc_one <= acc_one ^ rsp_one.result;
            acc_two <= acc_two ^ rsp_two.result;
          end
        end
        ST_MERGE_ONE: acc_one <= merge_one;
        ST_MERGE_TWO: acc_two <= merge_two;
        ST_FIN_XOR:   acc_one <= (acc_one ^ total_bytes) + (acc_two ^ total_bytes);
        ST_FIN_ADD:   acc_two <= (acc_two ^ total_bytes) + acc_one;
        ST_FIN_SUM_1: acc_one <= rsp_one.result + rsp_two.result;
        ST_FIN_SUM_2: acc_two <= rsp_two.result + acc_one;
        ST_EMIT: begin
          if (out_free) begin
            dig_low     <= acc_one;
            dig_high    <= acc_two;
            acc_one     <= '0;
            acc_two     <= '0;
            total_bytes <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign blk.ready          = (state == ST_IDLE);
  assign digest.valid       = out_valid;
  assign digest.digest_low  = dig_low;
  assign digest.digest_high = dig_high;

endmodule
`default_nettype wire

// ----- hw/rtl/mm3_checker.sv -----
`default_nettype none
module mm3_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        blk_valid,
  input wire logic        blk_ready,
  input wire logic        blk_last,
  input wire logic        dig_valid,
  input wire logic        dig_ready,
  input wire logic [63:0] dig_low,
  input wire logic [63:0] dig_high
);

  logic       blk_acc;
  logic       dig_acc;
  logic [1:0] pending;  // last words accepted whose digest is not yet taken

  assign blk_acc = blk_valid && blk_ready;
  assign dig_acc = dig_valid && dig_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
    end else begin
      pending <= pending + 2'(blk_acc && blk_last) - 2'(dig_acc);
    end
  end

  a_reset_quiet: assert property (@(posedge clk) rst |=> !dig_valid)
    else $error("digest valid right after reset");

  a_digest_has_message: assert property (@(posedge clk) disable iff (rst)
    dig_valid |-> pending != 2'd0)
    else $error("digest word with no last word behind it");

  a_two_open_blocks_input: assert property (@(posedge clk) disable iff (rst)
    pending == 2'd2 |-> !blk_acc)
    else $error("word accepted while two digests are outstanding");

  a_digest_holds: assert property (@(posedge clk) disable iff (rst)
    dig_valid && !dig_ready |=> dig_valid && $stable(dig_low) && $stable(dig_high))
    else $error("stalled digest word changed");

endmodule

bind murmur3_x64_128_hash_unit mm3_checker u_mm3_checker (
  .clk       (clk),
  .rst       (rst),
  .blk_valid (blk.valid),
  .blk_ready (blk.ready),
  .blk_last  (blk.last),
  .dig_valid (digest.valid),
  .dig_ready (digest.ready),
  .dig_low   (digest.digest_low),
  .dig_high  (digest.digest_high)
);
`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] K_C1   = 64'h87c37b91114253d5;
  localparam logic [63:0] K_C2   = 64'h4cf5ad432745937f;
  localparam logic [63:0] K_ADD1 = 64'h0000000052dce729;
  localparam logic [63:0] K_ADD2 = 64'h0000000038495ab5;
  localparam logic [63:0] K_F1   = 64'hff51afd7ed558ccd;
  localparam logic [63:0] K_F2   = 64'hc4ceb9fe1a85ec53;

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_TAIL  = 40;

  typedef struct packed {
    logic [mm3_pkg::LANE_W-1:0]  low;
    logic [mm3_pkg::LANE_W-1:0]  high;
    logic [mm3_pkg::COUNT_W-1:0] count;
    logic                        last;
  } block_word_t;

  typedef struct packed {
    logic [mm3_pkg::LANE_W-1:0] low;
    logic [mm3_pkg::LANE_W-1:0] high;
  } digest_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                        in_valid = 1'b0;
  logic [mm3_pkg::LANE_W-1:0]  in_low   = '0;
  logic [mm3_pkg::LANE_W-1:0]  in_high  = '0;
  logic [mm3_pkg::COUNT_W-1:0] in_count = '0;
  logic                        in_last  = 1'b0;
  logic                        out_ready = 1'b0;

  mm3_block_if  blk_if ();
  mm3_digest_if dig_if ();

  assign blk_if.valid      = in_valid;
  assign blk_if.lane_low   = in_low;
  assign blk_if.lane_high  = in_high;
  assign blk_if.byte_count = in_count;
  assign blk_if.last       = in_last;
  assign dig_if.ready      = out_ready;

  murmur3_x64_128_hash_unit uut (
    .clk    (clk),
    .rst    (rst),
    .blk    (blk_if),
    .digest (dig_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  block_word_t block_words[$];
  digest_t     pending_digests[$];

  // hash state mirrored from the accepted word stream
  logic [63:0] run_h1 = '0;
  logic [63:0] run_h2 = '0;
  logic [63:0] run_len = '0;

  int  error_count = 0;
  bit  steady = 1'b0;
  bit  hold_req = 1'b0;
  bit  hold_used = 1'b0;
  int  hold_left = 0;
  int  idle_cycles = 0;

  function automatic logic [63:0] rotl64(logic [63:0] v, int unsigned s);
    return (v << s) | (v >> (64 - s));
  endfunction

  function automatic logic [63:0] fmix64(logic [63:0] v);
    v = v ^ (v >> 33);
    v = v * K_F1;
    v = v ^ (v >> 33);
    v = v * K_F2;
    v = v ^ (v >> 33);
    return v;
  endfunction

  function automatic logic [63:0] mix_k1(logic [63:0] k);
    return rotl64(k * K_C1, 31) * K_C2;
  endfunction

  function automatic logic [63:0] mix_k2(logic [63:0] k);
    return rotl64(k * K_C2, 33) * K_C1;
  endfunction

  function automatic logic [63:0] keep_bytes(int unsigned n);
    if (n >= 8) return '1;
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  task automatic mix_body(logic [63:0] lo, logic [63:0] hi);
    run_h1 = rotl64(run_h1 ^ mix_k1(lo), 27) + run_h2;
    run_h1 = run_h1 * 64'd5 + K_ADD1;
    run_h2 = rotl64(run_h2 ^ mix_k2(hi), 31) + run_h1;
    run_h2 = run_h2 * 64'd5 + K_ADD2;
  endtask

  // Advance the mirrored hash by one accepted word; a last word queues its digest.
  task automatic absorb_word(block_word_t w);
    logic [63:0] h1, h2;
    int unsigned n;
    if (!w.last) begin
      mix_body(w.low, w.high);
      run_len = run_len + 64'd16;
    end else begin
      n = (w.count > 16) ? 16 : w.count;
      if (n == 16) begin
        mix_body(w.low, w.high);
      end else begin
        if (n > 8) run_h2 = run_h2 ^ mix_k2(w.high & keep_bytes(n - 8));
        if (n > 0) run_h1 = run_h1 ^ mix_k1(w.low & keep_bytes(n));
      end
      run_len = run_len + 64'(n);
      h1 = run_h1 ^ run_len;
      h2 = run_h2 ^ run_len;
      h1 = h1 + h2;
      h2 = h2 + h1;
      h1 = fmix64(h1);
      h2 = fmix64(h2);
      h1 = h1 + h2;
      h2 = h2 + h1;
      pending_digests.push_back('{low: h1, high: h2});
      run_h1 = '0;
      run_h2 = '0;
      run_len = '0;
    end
  endtask

  // sender
  always @(posedge clk) begin
    block_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && blk_if.ready)
        absorb_word('{low: in_low, high: in_high, count: in_count, last: in_last});
      if (!in_valid || blk_if.ready) begin
        if (block_words.size() != 0 && (steady || $urandom_range(0, 99) >= 10)) begin
          w = block_words.pop_front();
          in_valid <= 1'b1;
          in_low   <= w.low;
          in_high  <= w.high;
          in_count <= w.count;
          in_last  <= w.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver hold-off, one long stretch
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    digest_t exp_d;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (dig_if.valid && out_ready) begin
        if (pending_digests.size() == 0) begin
          error_count++;
          $display("%0t: unexpected digest low=%h high=%h", $time,
                   dig_if.digest_low, dig_if.digest_high);
        end else begin
          exp_d = pending_digests.pop_front();
          if (dig_if.digest_low !== exp_d.low) begin
            error_count++;
            $display("%0t: digest_low expected %h actual %h", $time,
                     exp_d.low, dig_if.digest_low);
          end
          if (dig_if.digest_high !== exp_d.high) begin
            error_count++;
            $display("%0t: digest_high expected %h actual %h", $time,
                     exp_d.high, dig_if.digest_high);
          end
        end
      end
      out_ready <= (hold_left == 0) && (steady || $urandom_range(0, 99) >= 10);
    end
  end

  // watchdog: cycles in which neither side moves a word
  always @(posedge clk) begin
    if (rst || (in_valid && blk_if.ready) || (dig_if.valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_word(logic [63:0] lo, logic [63:0] hi, logic [4:0] cnt, logic lst);
    block_words.push_back('{low: lo, high: hi, count: cnt, last: lst});
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Random messages, mostly short so digests are frequent; count on body words is noise.
  task automatic queue_random_messages(int words);
    int queued, body, pick;
    logic [4:0] cnt;
    queued = 0;
    while (queued < words) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) body = $urandom_range(0, 3);
      else if (pick < 97) body = $urandom_range(4, 12);
      else body = $urandom_range(13, 40);
      repeat (body) push_word(rand64(), rand64(), 5'($urandom_range(0, 31)), 1'b0);
      if ($urandom_range(0, 99) < 20) cnt = 5'($urandom_range(0, 31));
      else cnt = 5'($urandom_range(0, 16));
      push_word(rand64(), rand64(), cnt, 1'b1);
      queued += body + 1;
    end
  endtask

  task automatic wait_drained();
    while (block_words.size() != 0 || in_valid || pending_digests.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty message, full and partial tails, saturated count, ignored count
    push_word(rand64(), rand64(), 5'd0, 1'b1);
    push_word('1, '1, 5'd16, 1'b1);
    push_word('1, '1, 5'd1, 1'b1);
    push_word('1, '1, 5'd7, 1'b1);
    push_word('1, '1, 5'd8, 1'b1);
    push_word('1, '1, 5'd9, 1'b1);
    push_word('1, '1, 5'd15, 1'b1);
    push_word('1, '1, 5'd17, 1'b1);
    push_word('0, '0, 5'd31, 1'b1);
    push_word('0, '0, 5'd0, 1'b0);
    push_word('1, '1, 5'd31, 1'b0);
    push_word(rand64(), rand64(), 5'd12, 1'b1);
    push_word('0, '1, 5'd3, 1'b0);
    push_word('1, '0, 5'd16, 1'b1);
    wait_drained();

    queue_random_messages(700);
    wait_drained();

    // no idling on either side
    steady = 1'b1;
    queue_random_messages(300);
    wait_drained();
    steady = 1'b0;

    // receiver stalls long while words keep coming
    queue_random_messages(700);
    hold_req = 1'b1;
    wait_drained();

    repeat (DRAIN_TAIL) @(negedge clk);
    if (error_count == 0 && pending_digests.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
